// ----- sv/cega_pkg.sv -----
`timescale 1ns / 1ps

package cega_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int CHG_W   = 16;
    localparam int SUM_W   = 48;

    // Derived datapath widths
    localparam int DIFF_W  = COORD_W + 1;          // central minus neighbour
    localparam int S_W     = 2 * DIFF_W;           // sum of three squares
    localparam int RX_W    = S_W + 12;             // radicand, s << 12
    localparam int RES_W   = RX_W + 1;             // root working register
    localparam int R_W     = RX_W / 2;             // final root
    localparam int P_W     = 2 * CHG_W + 9;        // 331 * |qc| * |q|
    localparam int EMAG_W  = P_W + 10;             // energy term magnitude
    localparam int PROD_W  = EMAG_W + DIFF_W;      // |E| * |D|
    localparam int NUM_W   = PROD_W + 12;          // divider numerator
    localparam int DEN_W   = S_W;                  // divider denominator
    localparam int MAG_W   = SUM_W + 2;            // clamped term magnitude
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int MCNT_W  = $clog2(DIFF_W);

    localparam logic [8:0] COULOMB_K = 9'd331;

    // Configuration register indexes
    localparam logic [1:0] CFG_X = 2'd0;
    localparam logic [1:0] CFG_Y = 2'd1;
    localparam logic [1:0] CFG_Z = 2'd2;
    localparam logic [1:0] CFG_Q = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] atom_x;
        logic signed [COORD_W-1:0] atom_y;
        logic signed [COORD_W-1:0] atom_z;
        logic signed [CHG_W-1:0]   atom_charge;
        logic                      last_atom;
    } t_in;

    typedef struct packed {
        logic signed [SUM_W-1:0] energy_sum;
        logic signed [SUM_W-1:0] gradient_x;
        logic signed [SUM_W-1:0] gradient_y;
        logic signed [SUM_W-1:0] gradient_z;
        logic                    range_fault;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_SQ, S_ZCHK, S_SQRT, S_EDGO, S_EDIV, S_EACC,
        S_GCHK, S_GMUL, S_GDGO, S_GDIV, S_GACC, S_GNEXT, S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic sq;
        logic sqrt_init;
        logic sqrt_step;
        logic ediv_start;
        logic eacc;
        logic gmul_init;
        logic gmul_step;
        logic gdiv_start;
        logic gacc;
        logic axis_next;
        logic emit;
        logic fault_zero;
    } t_cmd;

    typedef struct packed {
        logic q_zero;
        logic last;
        logic sq_last;
        logic s_zero;
        logic sqrt_last;
        logic div_done;
        logic mul_last;
        logic axis_skip;
        logic axis_last;
        logic out_free;
    } t_stat;

    // Saturating add of a signed magnitude; returns {fault, new value}
    function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] acc,
                                               input logic neg,
                                               input logic [MAG_W-1:0] mag);
        logic signed [MAG_W+1:0] ext;
        logic signed [MAG_W+1:0] m;
        logic signed [MAG_W+1:0] sum;
        logic signed [MAG_W+1:0] hi;
        logic signed [MAG_W+1:0] lo;
        logic [SUM_W:0] res;
        ext = {{(MAG_W+2-SUM_W){acc[SUM_W-1]}}, acc};
        m   = {2'b00, mag};
        sum = neg ? (ext - m) : (ext + m);
        hi  = {{(MAG_W+3-SUM_W){1'b0}}, {(SUM_W-1){1'b1}}};
        lo  = ~hi;
        if (sum > hi) begin
            res = {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
        end else if (sum < lo) begin
            res = {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            res = {1'b0, sum[SUM_W-1:0]};
        end
        return res;
    endfunction

    // Quotient clamped to the term magnitude width
    function automatic logic [MAG_W-1:0] clamp_mag(input logic [NUM_W-1:0] q);
        return (|q[NUM_W-1:MAG_W]) ? {MAG_W{1'b1}} : q[MAG_W-1:0];
    endfunction

endpackage

// ----- sv/coulomb_energy_gradient_accumulator.sv -----
`timescale 1ns / 1ps
// Per atom: a zero-charge atom goes straight to the finish state and a zero-distance
// atom sets the range fault; a charged atom runs the bit-serial square root, the
// shared restoring divider for the energy term and, per gradient axis, the serial
// multiplier and the divider again (an axis with a zero difference or term is skipped).
// Throughput: one atom at a time; a last atom holds while the result is untaken.
// Reset: synchronous active low; clears configuration, sums, fault flag and output valid.

module coulomb_energy_gradient_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cega_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cega_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [cega_pkg::COORD_W-1:0]   i_cfg_data
);
    import cega_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    cega_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cega_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/cega_div.sv -----
`timescale 1ns / 1ps

module cega_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cega_pkg::NUM_W-1:0] i_num,
    input  logic [cega_pkg::DEN_W-1:0] i_den,
    output logic                        o_done,
    output logic [cega_pkg::NUM_W-1:0] o_quo
);
    import cega_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    // One quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign take   = rem_sh >= {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == CNT_W'(NUM_W - 1));
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], take};
            r_rem <= take ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        end
    end

endmodule

// ----- sv/cega_ctrl.sv -----
`timescale 1ns / 1ps

module cega_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cega_pkg::t_stat i_stat,
    output cega_pkg::t_cmd  o_cmd
);
    import cega_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHK;
            S_CHK:   n_state = i_stat.q_zero ? S_FIN : S_SQ;
            S_SQ:    if (i_stat.sq_last) n_state = S_ZCHK;
            S_ZCHK:  n_state = i_stat.s_zero ? S_FIN : S_SQRT;
            S_SQRT:  if (i_stat.sqrt_last) n_state = S_EDGO;
            S_EDGO:  n_state = S_EDIV;
            S_EDIV:  if (i_stat.div_done) n_state = S_EACC;
            S_EACC:  n_state = S_GCHK;
            S_GCHK:  n_state = i_stat.axis_skip ? S_GNEXT : S_GMUL;
            S_GMUL:  if (i_stat.mul_last) n_state = S_GDGO;
            S_GDGO:  n_state = S_GDIV;
            S_GDIV:  if (i_stat.div_done) n_state = S_GACC;
            S_GACC:  n_state = S_GNEXT;
            S_GNEXT: n_state = i_stat.axis_last ? S_FIN : S_GCHK;
            S_FIN: begin
                if (!i_stat.last || i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SQ:   o_cmd.sq = 1'b1;
            S_ZCHK: begin
                o_cmd.fault_zero = i_stat.s_zero;
                o_cmd.sqrt_init  = !i_stat.s_zero;
            end
            S_SQRT: o_cmd.sqrt_step  = 1'b1;
            S_EDGO: o_cmd.ediv_start = 1'b1;
            S_EACC: o_cmd.eacc       = 1'b1;
            S_GCHK: o_cmd.gmul_init  = !i_stat.axis_skip;
            S_GMUL: o_cmd.gmul_step  = 1'b1;
            S_GDGO: o_cmd.gdiv_start = 1'b1;
            S_GACC: o_cmd.gacc       = 1'b1;
            S_GNEXT: o_cmd.axis_next = !i_stat.axis_last;
            S_FIN:  o_cmd.emit       = i_stat.last && i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- sv/cega_dp.sv -----
`timescale 1ns / 1ps

module cega_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cega_pkg::t_in         i_in_data,
    input  cega_pkg::t_cmd        i_cmd,
    output cega_pkg::t_stat       o_stat,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [cega_pkg::COORD_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cega_pkg::t_out        o_out_data
);
    import cega_pkg::*;

    // Configuration
    logic [COORD_W-1:0] r_cpos [3];
    logic [CHG_W-1:0]   r_cq;

    // Per-atom operands
    logic [DIFF_W-1:0]  r_dm [3];
    logic [2:0]         r_dneg;
    logic [CHG_W-1:0]   r_qm;
    logic               r_pneg;
    logic               r_qz;
    logic               r_last;
    logic [S_W-1:0]     r_s;
    logic [2*CHG_W-1:0] r_pp;
    logic [P_W-1:0]     r_p;
    logic [EMAG_W-1:0]  r_emag;
    logic [1:0]         r_axis;
    logic [MCNT_W-1:0]  r_cnt;

    // Square root
    logic [RX_W-1:0]    r_sx;
    logic [RES_W-1:0]   r_sres;
    logic [RES_W-1:0]   r_sbit;
    logic [RES_W-1:0]   sq_t;

    // Serial multiplier
    logic [PROD_W-1:0]  r_prod;
    logic [DIFF_W-1:0]  r_mq;

    // Accumulators and result
    logic signed [SUM_W-1:0] r_eacc;
    logic signed [SUM_W-1:0] r_gacc [3];
    logic               r_fault;
    logic               r_out_valid;
    t_out               r_out;

    logic [COORD_W-1:0] apos [3];
    logic [DIFF_W-1:0]  dif  [3];
    logic [CHG_W:0]     qabs;
    logic [CHG_W:0]     qcabs;
    logic [DIFF_W-1:0]  dm_sel;
    logic [S_W-1:0]     dm_sq;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic [MAG_W-1:0]   term;
    logic [SUM_W:0]     e_new;
    logic [SUM_W:0]     g_new;

    assign apos[0] = i_in_data.atom_x;
    assign apos[1] = i_in_data.atom_y;
    assign apos[2] = i_in_data.atom_z;

    // Differences and charge magnitudes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dif[k] = {r_cpos[k][COORD_W-1], r_cpos[k]} - {apos[k][COORD_W-1], apos[k]};
        end
        qabs  = i_in_data.atom_charge[CHG_W-1]
              ? (CHG_W+1)'(-$signed({1'b1, i_in_data.atom_charge}))
              : {1'b0, i_in_data.atom_charge};
        qcabs = r_cq[CHG_W-1] ? (CHG_W+1)'(-$signed({1'b1, r_cq})) : {1'b0, r_cq};
    end

    assign dm_sel = r_dm[r_cnt[1:0]];
    assign dm_sq  = dm_sel * dm_sel;
    assign sq_t   = r_sres + r_sbit;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpos[0] <= '0;
            r_cpos[1] <= '0;
            r_cpos[2] <= '0;
            r_cq      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_X:   r_cpos[0] <= i_cfg_data;
                CFG_Y:   r_cpos[1] <= i_cfg_data;
                CFG_Z:   r_cpos[2] <= i_cfg_data;
                CFG_Q:   r_cq      <= i_cfg_data[CHG_W-1:0];
                default: r_cq      <= r_cq;
            endcase
        end
    end

    // Operand capture, squares and charge product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_dneg[k] <= dif[k][DIFF_W-1];
                r_dm[k]   <= dif[k][DIFF_W-1] ? DIFF_W'(-dif[k]) : dif[k];
            end
            r_qm   <= qabs[CHG_W-1:0];
            r_pneg <= r_cq[CHG_W-1] != i_in_data.atom_charge[CHG_W-1];
            r_qz   <= (i_in_data.atom_charge == '0);
            r_last <= i_in_data.last_atom;
            r_s    <= '0;
            r_cnt  <= '0;
            r_axis <= '0;
        end else if (i_cmd.sq) begin
            r_s   <= r_s + dm_sq;
            r_pp  <= qcabs[CHG_W-1:0] * r_qm;
            r_p   <= P_W'(r_pp * COULOMB_K);
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.gmul_init) begin
            r_prod <= '0;
            r_mq   <= r_dm[r_axis];
            r_cnt  <= '0;
        end else if (i_cmd.gmul_step) begin
            r_prod <= {r_prod[PROD_W-2:0], 1'b0}
                    + (r_mq[DIFF_W-1] ? PROD_W'(r_emag) : '0);
            r_mq   <= {r_mq[DIFF_W-2:0], 1'b0};
            r_cnt  <= r_cnt + 1'b1;
        end else if (i_cmd.axis_next) begin
            r_axis <= r_axis + 1'b1;
        end
        if (i_cmd.eacc) begin
            r_emag <= div_quo[EMAG_W-1:0];
        end
    end

    // Bit-pair square root
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sx   <= {r_s, 12'b0};
            r_sres <= '0;
            r_sbit <= {1'b1, {(RES_W-1){1'b0}}};
        end else if (i_cmd.sqrt_step) begin
            if ({1'b0, r_sx} >= sq_t) begin
                r_sx   <= RX_W'({1'b0, r_sx} - sq_t);
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    // Shared divider
    assign div_start = i_cmd.ediv_start || i_cmd.gdiv_start;
    assign div_num   = i_cmd.ediv_start ? NUM_W'({r_p, 10'b0}) : {r_prod, 12'b0};
    assign div_den   = i_cmd.ediv_start ? DEN_W'(r_sres[R_W-1:0]) : r_s;

    cega_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign term  = clamp_mag(div_quo);
    assign e_new = sat_add(r_eacc, r_pneg, term);
    assign g_new = sat_add(r_gacc[r_axis], r_pneg == r_dneg[r_axis], term);

    // Accumulators and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eacc      <= '0;
            r_gacc[0]   <= '0;
            r_gacc[1]   <= '0;
            r_gacc[2]   <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.fault_zero) begin
                r_fault <= 1'b1;
            end
            if (i_cmd.eacc) begin
                r_eacc <= e_new[SUM_W-1:0];
                if (e_new[SUM_W]) r_fault <= 1'b1;
            end
            if (i_cmd.gacc) begin
                r_gacc[r_axis] <= g_new[SUM_W-1:0];
                if (g_new[SUM_W]) r_fault <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_eacc      <= '0;
                r_gacc[0]   <= '0;
                r_gacc[1]   <= '0;
                r_gacc[2]   <= '0;
                r_fault     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.energy_sum  <= r_eacc;
            r_out.gradient_x  <= r_gacc[0];
            r_out.gradient_y  <= r_gacc[1];
            r_out.gradient_z  <= r_gacc[2];
            r_out.range_fault <= r_fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status to the controller
    always_comb begin
        o_stat.q_zero    = r_qz;
        o_stat.last      = r_last;
        o_stat.sq_last   = (r_cnt[1:0] == 2'd2);
        o_stat.s_zero    = (r_s == '0);
        o_stat.sqrt_last = r_sbit[0];
        o_stat.div_done  = div_done;
        o_stat.mul_last  = (r_cnt == MCNT_W'(DIFF_W - 1));
        o_stat.axis_skip = (r_dm[r_axis] == '0) || (r_emag == '0);
        o_stat.axis_last = (r_axis == 2'd2);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result emitted over an untaken transaction");

    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_eacc == '0) && !r_fault && r_out_valid)
        else $error("accumulators not cleared after emit");

    a_root_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> (r_sbit != '0))
        else $error("square root stepped past its last digit");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (div_den != '0))
        else $error("divider started with zero denominator");
`endif

endmodule
